[rtl/core/wvm_pkg.sv]
// ----------------------------------------------------------------------------
// wvm_pkg: shared types and constants
// Opcodes, status codes, sequencer states and defaults for the word VM core.
// ----------------------------------------------------------------------------
package wvm_pkg;

   localparam int MemWordsDefault   = 32768;
   localparam int StackDepthDefault = 4096;

   localparam logic [15:0] REG_BASE  = 16'h8000;
   localparam logic [15:0] REG_LIMIT = 16'h8008;
   localparam logic [14:0] WORD_MASK = 15'h7FFF;

   typedef enum logic [4:0] {
      OP_HALT = 5'd0,  OP_SET  = 5'd1,  OP_PUSH = 5'd2,  OP_POP  = 5'd3,
      OP_EQ   = 5'd4,  OP_GT   = 5'd5,  OP_JMP  = 5'd6,  OP_JT   = 5'd7,
      OP_JF   = 5'd8,  OP_ADD  = 5'd9,  OP_MULT = 5'd10, OP_MOD  = 5'd11,
      OP_AND  = 5'd12, OP_OR   = 5'd13, OP_NOT  = 5'd14, OP_RMEM = 5'd15,
      OP_WMEM = 5'd16, OP_CALL = 5'd17, OP_RET  = 5'd18, OP_OUT  = 5'd19,
      OP_IN   = 5'd20, OP_NOOP = 5'd21
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_CHAR      = 3'd1,
      ST_HALTED    = 3'd2,
      ST_BAD_OPND  = 3'd3,
      ST_BAD_OP    = 3'd4,
      ST_UNDERFLOW = 3'd5,
      ST_MOD_ZERO  = 3'd6,
      ST_OVERFLOW  = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH, S_WAIT, S_CAPT, S_DECODE, S_DIV,
      S_RMEM, S_RMEMW, S_POPW, S_RETW, S_WRITE, S_RESP
   } state_type;

   typedef struct packed {
      logic        start;
      logic [14:0] dividend;
      logic [14:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [14:0] remainder;
   } div_rsp_type;

endpackage

[rtl/core/wvm_if.sv]
// ----------------------------------------------------------------------------
// wvm_req_if / wvm_rsp_if: valid/ready channels
// Request and response channels of the word VM core.
// ----------------------------------------------------------------------------
interface wvm_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [14:0] load_addr;
   logic [15:0] load_data;
   logic [7:0]  in_char;
   modport source (output valid, req_type, load_addr, load_data, in_char, input ready);
   modport sink   (input valid, req_type, load_addr, load_data, in_char, output ready);
endinterface

interface wvm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  out_char;
   logic        used_input;
   logic [14:0] pc_after;
   modport source (output valid, status, out_char, used_input, pc_after, input ready);
   modport sink   (input valid, status, out_char, used_input, pc_after, output ready);
endinterface

[rtl/core/word_vm_instruction_core.sv]
// ----------------------------------------------------------------------------
// word_vm_instruction_core: 15-bit word virtual machine
// Sequencer, register file, word memory, stack and remainder unit.
// ----------------------------------------------------------------------------
// A load transfer writes one memory word in S_FETCH, and its response is
// then registered in S_RESP.
// A step transfer executes one instruction. The sequencer always reads the
// opcode and three operand words through the single memory port: it issues
// the first read in S_FETCH, then spends S_WAIT and S_CAPT on each word.
// It then decodes in S_DECODE, passes S_WRITE for the register write-back
// and registers the response in S_RESP. Extra work adds states:
//   - POP and RET add S_POPW or S_RETW for the stack read.
//   - RMEM adds S_RMEM and S_RMEMW for the extra memory read.
//   - MOD adds S_DIV, which waits for the bit-serial remainder unit.
// A step on a stopped machine answers like a load.
// Request ready is low while an item is in work and while its response sits
// in the output register. The next request is therefore taken at the
// earliest in the cycle after the response transfer.
// Memory and stack RAMs are not cleared.
module word_vm_instruction_core
   import wvm_pkg::*;
#(
   parameter int MEM_WORDS   = MemWordsDefault,
   parameter int STACK_DEPTH = StackDepthDefault
) (
   input  logic      clock,
   input  logic      reset,
   wvm_req_if.sink   req,
   wvm_rsp_if.source rsp
);
   localparam int MA = $clog2(MEM_WORDS);
   localparam int SA = $clog2(STACK_DEPTH);
   localparam int SL = $clog2(STACK_DEPTH + 1);

   state_type   state_ff, state_in;
   logic        kind_ff, kind_in;
   logic [14:0] la_ff, la_in;
   logic [15:0] ld_ff, ld_in;
   logic [7:0]  ch_ff, ch_in;
   logic [15:0] w_ff [4];
   logic [15:0] w_in [4];
   logic [1:0]  widx_ff, widx_in;
   logic [14:0] pc_ff, pc_in;
   logic [2:0]  stop_ff, stop_in;
   logic [SL-1:0] sp_ff, sp_in;
   logic [14:0] gpr_ff [8];
   logic [2:0]  dst_ff, dst_in;
   logic [14:0] res_ff, res_in;
   logic        wr_ff, wr_in;
   logic        rv_ff, rv_in;
   logic [2:0]  rs_ff, rs_in;
   logic [7:0]  ro_ff, ro_in;
   logic        ru_ff, ru_in;

   // memory port
   logic        m_we;
   logic [14:0] m_addr15;
   logic [15:0] m_wd, m_rd;
   logic        m_out_ff, m_out_in;
   logic        s_we;
   logic [SA-1:0] s_addr;
   logic [14:0] s_wd, s_rd;

   div_req_type dreq;
   div_rsp_type drsp;

   wvm_ram #(.Width(16), .Depth(MEM_WORDS)) u_mem (
      .clock(clock), .we(m_we), .addr(m_addr15[MA-1:0]), .wdata(m_wd), .rdata(m_rd));
   wvm_ram #(.Width(15), .Depth(STACK_DEPTH)) u_stk (
      .clock(clock), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));
   wvm_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // operand decode
   logic [15:0] op_w;
   logic        r1, v1, v2, v3;
   logic [14:0] a, b, c;
   logic [15:0] addsum;
   logic [29:0] prod;

   function automatic logic isreg(input logic [15:0] w);
      return (w >= REG_BASE) && (w < REG_LIMIT);
   endfunction

   always_comb begin
      op_w = w_ff[0];
      r1 = isreg(w_ff[1]);
      v1 = w_ff[1] < REG_LIMIT;
      v2 = w_ff[2] < REG_LIMIT;
      v3 = w_ff[3] < REG_LIMIT;
      a = w_ff[1][15] ? gpr_ff[w_ff[1][2:0]] : w_ff[1][14:0];
      b = w_ff[2][15] ? gpr_ff[w_ff[2][2:0]] : w_ff[2][14:0];
      c = w_ff[3][15] ? gpr_ff[w_ff[3][2:0]] : w_ff[3][14:0];
      addsum = {1'b0, b} + {1'b0, c};
      prod = b * c;
   end

   logic [14:0] fetch_addr;
   logic        stk_full, stk_empty;
   assign fetch_addr = 15'(pc_ff + {13'd0, widx_ff});
   assign stk_full  = sp_ff >= SL'(STACK_DEPTH);
   assign stk_empty = sp_ff == '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid && !rv_ff) state_in = S_FETCH;
         S_FETCH: begin
            if (!kind_ff) state_in = S_RESP;
            else if (stop_ff != ST_OK) state_in = S_RESP;
            else state_in = S_WAIT;
         end
         S_WAIT: state_in = S_CAPT;
         S_CAPT: state_in = (widx_ff == 2'd3) ? S_DECODE : S_WAIT;
         S_DECODE: begin
            state_in = S_WRITE;
            if (op_w == 16'(OP_MOD) && r1 && v2 && v3 && c != '0) state_in = S_DIV;
            else if (op_w == 16'(OP_RMEM) && r1 && v2) state_in = S_RMEM;
            else if (op_w == 16'(OP_POP) && r1 && !stk_empty) state_in = S_POPW;
            else if (op_w == 16'(OP_RET) && !stk_empty) state_in = S_RETW;
         end
         S_DIV:   if (drsp.done) state_in = S_WRITE;
         S_RMEM:  state_in = S_RMEMW;
         S_RMEMW: state_in = S_WRITE;
         S_POPW:  state_in = S_WRITE;
         S_RETW:  state_in = S_WRITE;
         S_WRITE: state_in = S_RESP;
         S_RESP:  if (!rv_ff || rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      kind_in = kind_ff; la_in = la_ff; ld_in = ld_ff; ch_in = ch_ff;
      for (int i = 0; i < 4; i++) w_in[i] = w_ff[i];
      widx_in = widx_ff; pc_in = pc_ff; stop_in = stop_ff; sp_in = sp_ff;
      dst_in = dst_ff; res_in = res_ff; wr_in = 1'b0;
      rv_in = rv_ff; rs_in = rs_ff; ro_in = ro_ff; ru_in = ru_ff;
      m_we = 1'b0; m_addr15 = fetch_addr; m_wd = ld_ff; m_out_in = 1'b0;
      s_we = 1'b0; s_addr = sp_ff[SA-1:0]; s_wd = a;
      dreq.start = 1'b0; dreq.dividend = b; dreq.divisor = c;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && !rv_ff) begin
               kind_in = req.req_type; la_in = req.load_addr;
               ld_in = req.load_data; ch_in = req.in_char;
               widx_in = 2'd0;
            end
         end
         S_FETCH: begin
            rs_in = stop_ff; ro_in = '0; ru_in = 1'b0;
            if (!kind_ff) begin
               m_addr15 = la_ff;
               m_we = (32'(la_ff) < MEM_WORDS);
            end else if (stop_ff == ST_OK) begin
               m_out_in = 32'(fetch_addr) < MEM_WORDS;
            end
         end
         // hold the in-range flag of the word being read
         S_WAIT: m_out_in = m_out_ff;
         S_CAPT: begin
            w_in[widx_ff] = m_out_ff ? m_rd : 16'd0;
            if (widx_ff != 2'd3) begin
               widx_in = widx_ff + 2'd1;
               m_addr15 = 15'(pc_ff + {13'd0, widx_in});
               m_out_in = 32'(m_addr15) < MEM_WORDS;
            end
         end
         S_DECODE: begin
            dst_in = w_ff[1][2:0];
            rs_in = ST_OK;
            priority case (op_w)
               16'(OP_HALT): rs_in = ST_HALTED;
               16'(OP_SET), 16'(OP_NOT): begin
                  if (!r1 || !v2) rs_in = ST_BAD_OPND;
                  else begin
                     res_in = (op_w == 16'(OP_SET)) ? b : ~b;
                     wr_in = 1'b1; pc_in = 15'(pc_ff + 15'd3);
                  end
               end
               16'(OP_RMEM): begin
                  if (!r1 || !v2) rs_in = ST_BAD_OPND;
                  else begin
                     m_addr15 = b;
                     pc_in = 15'(pc_ff + 15'd3);
                  end
               end
               16'(OP_PUSH): begin
                  if (!v1) rs_in = ST_BAD_OPND;
                  else if (stk_full) rs_in = ST_OVERFLOW;
                  else begin
                     s_we = 1'b1; s_wd = a; sp_in = sp_ff + SL'(1);
                     pc_in = 15'(pc_ff + 15'd2);
                  end
               end
               16'(OP_POP): begin
                  if (!r1) rs_in = ST_BAD_OPND;
                  else if (stk_empty) rs_in = ST_UNDERFLOW;
                  else begin
                     sp_in = sp_ff - SL'(1); s_addr = SA'(sp_ff - SL'(1));
                     pc_in = 15'(pc_ff + 15'd2);
                  end
               end
               16'(OP_EQ), 16'(OP_GT), 16'(OP_ADD), 16'(OP_MULT), 16'(OP_MOD),
               16'(OP_AND), 16'(OP_OR): begin
                  if (!r1 || !v2 || !v3) rs_in = ST_BAD_OPND;
                  else if (op_w == 16'(OP_MOD) && c == '0) rs_in = ST_MOD_ZERO;
                  else begin
                     pc_in = 15'(pc_ff + 15'd4);
                     wr_in = (op_w != 16'(OP_MOD));
                     unique case (op_w)
                        16'(OP_EQ):   res_in = {14'd0, b == c};
                        16'(OP_GT):   res_in = {14'd0, b > c};
                        16'(OP_ADD):  res_in = addsum[14:0];
                        16'(OP_MULT): res_in = prod[14:0];
                        16'(OP_AND):  res_in = b & c;
                        16'(OP_OR):   res_in = b | c;
                        default: begin
                           res_in = res_ff;
                           dreq.start = 1'b1;
                        end
                     endcase
                  end
               end
               16'(OP_JMP): begin
                  if (!v1) rs_in = ST_BAD_OPND; else pc_in = a;
               end
               16'(OP_JT), 16'(OP_JF): begin
                  if (!v1 || !v2) rs_in = ST_BAD_OPND;
                  else if ((op_w == 16'(OP_JT)) == (a != '0)) pc_in = b;
                  else pc_in = 15'(pc_ff + 15'd3);
               end
               16'(OP_WMEM): begin
                  if (!v1 || !v2) rs_in = ST_BAD_OPND;
                  else begin
                     m_addr15 = a; m_wd = {1'b0, b};
                     m_we = 32'(a) < MEM_WORDS;
                     pc_in = 15'(pc_ff + 15'd3);
                  end
               end
               16'(OP_CALL): begin
                  if (!v1) rs_in = ST_BAD_OPND;
                  else if (stk_full) rs_in = ST_OVERFLOW;
                  else begin
                     s_we = 1'b1; s_wd = 15'(pc_ff + 15'd2);
                     sp_in = sp_ff + SL'(1); pc_in = a;
                  end
               end
               16'(OP_RET): begin
                  if (stk_empty) rs_in = ST_HALTED;
                  else begin
                     sp_in = sp_ff - SL'(1); s_addr = SA'(sp_ff - SL'(1));
                  end
               end
               16'(OP_OUT): begin
                  if (!v1) rs_in = ST_BAD_OPND;
                  else begin
                     rs_in = ST_CHAR; ro_in = a[7:0];
                     pc_in = 15'(pc_ff + 15'd2);
                  end
               end
               16'(OP_IN): begin
                  if (!r1) rs_in = ST_BAD_OPND;
                  else begin
                     res_in = {7'd0, ch_ff}; wr_in = 1'b1; ru_in = 1'b1;
                     pc_in = 15'(pc_ff + 15'd2);
                  end
               end
               16'(OP_NOOP): pc_in = 15'(pc_ff + 15'd1);
               default: rs_in = ST_BAD_OP;
            endcase
            if (rs_in != ST_OK && rs_in != ST_CHAR) stop_in = rs_in;
            if (op_w == 16'(OP_RMEM) && r1 && v2) m_out_in = 32'(b) < MEM_WORDS;
         end
         S_DIV: if (drsp.done) begin
            res_in = drsp.remainder; wr_in = 1'b1;
         end
         // keep the RMEM address on the port so the read data holds
         S_RMEM: begin
            m_addr15 = b;
            m_out_in = m_out_ff;
         end
         S_RMEMW: begin
            res_in = m_out_ff ? m_rd[14:0] : 15'd0; wr_in = 1'b1;
         end
         S_POPW: begin
            res_in = s_rd; wr_in = 1'b1;
         end
         S_RETW: pc_in = s_rd;
         S_WRITE: ;
         S_RESP: begin
            if (!rv_ff || rsp.ready) rv_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= '0;
         stop_ff  <= ST_OK;
         sp_ff    <= '0;
         rv_ff    <= 1'b0;
         wr_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) gpr_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         stop_ff  <= stop_in;
         sp_ff    <= sp_in;
         rv_ff    <= rv_in;
         wr_ff    <= wr_in;
         if (wr_ff) gpr_ff[dst_ff] <= res_ff;
      end
      kind_ff <= kind_in; la_ff <= la_in; ld_ff <= ld_in; ch_ff <= ch_in;
      for (int i = 0; i < 4; i++) w_ff[i] <= w_in[i];
      widx_ff <= widx_in; dst_ff <= dst_in; res_ff <= res_in;
      rs_ff <= rs_in; ro_ff <= ro_in; ru_ff <= ru_in;
      m_out_ff <= m_out_in;
   end

   assign req.ready      = (state_ff == S_IDLE) && !rv_ff;
   assign rsp.valid      = rv_ff;
   assign rsp.status     = rs_ff;
   assign rsp.out_char   = ro_ff;
   assign rsp.used_input = ru_ff;
   assign rsp.pc_after   = pc_ff;

   // request ready is only raised in the idle state
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   // a stopped machine never changes its stop code
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stop_ff != ST_OK |=> stop_ff == $past(stop_ff))
      else $error("stop code changed");
   // divider only runs during the modulo state
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      drsp.busy |-> state_ff == S_DIV)
      else $error("divider busy outside modulo");
endmodule

[rtl/core/wvm_ram.sv]
// ----------------------------------------------------------------------------
// wvm_ram: generic single-port RAM
// One read per cycle, plus a write when we is high, at the same address; registered read data.
// ----------------------------------------------------------------------------
module wvm_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

[rtl/core/wvm_div.sv]
// ----------------------------------------------------------------------------
// wvm_div: iterative remainder unit
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wvm_div
   import wvm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [14:0] rem_ff, rem_in;
   logic [14:0] quo_ff, quo_in;
   logic [14:0] dvs_ff, dvs_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [15:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[14]};
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
         cnt_in  = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[13:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 15'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[14:0];
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd14) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;
endmodule

[tb/sv/word_vm_instruction_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_vm_instruction_core_test: self-checking bench for the word VM core
// A directed program followed by random instructions. Each instruction's
// words are loaded into memory before it is stepped, so no unwritten word
// is ever fetched. A built-in machine model predicts each random response;
// directed rows are hand-typed. One fault near the end stops the machine.
// ----------------------------------------------------------------------------
module word_vm_instruction_core_test;
   import wvm_pkg::*;

   localparam int STACK_WORDS = 4096;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 60;

   typedef struct packed {
      bit        step;     // 0: load a word, 1: execute one instruction
      bit [14:0] addr;
      bit [15:0] data;
      bit [7:0]  ch;
   } vm_req_type;

   typedef struct packed {
      bit [2:0]  status;
      bit [7:0]  oc;
      bit        used;
      bit [14:0] pc;
   } vm_rsp_type;

   // directed row: request plus a hand-typed expected response
   typedef struct packed {
      vm_req_type req;
      vm_rsp_type rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wvm_req_if req_ch ();
   wvm_rsp_if rsp_ch ();

   word_vm_instruction_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #1 clock = ~clock;

   // -------------------------------------------------------------------------
   // Machine model state
   // -------------------------------------------------------------------------
   bit [15:0] vm_mem     [32768];
   bit        vm_written [32768];
   bit [14:0] vm_stack   [STACK_WORDS];
   bit [14:0] vm_regs    [8];
   int        vm_level;
   bit [14:0] vm_pc;
   bit [2:0]  vm_stop;

   vm_rsp_type pending_rsp [$];   // responses still owed by the core
   int        mismatches;
   int        sent_items;
   int        cycles;
   int        send_idle;
   int        recv_idle;

   function automatic bit [15:0] mem_word(input int a);
      return vm_mem[a & 'h7FFF];
   endfunction

   function automatic bit is_reg(input bit [15:0] w);
      return w >= REG_BASE && w < REG_LIMIT;
   endfunction

   function automatic bit operand(input bit [15:0] w, output bit [14:0] v);
      v = '0;
      if (w < REG_BASE) begin
         v = w[14:0];
         return 1'b1;
      end
      if (w < REG_LIMIT) begin
         v = vm_regs[w[2:0]];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Apply one request to the model and return the response it must produce.
   task automatic vm_execute(input vm_req_type it, output vm_rsp_type r);
      bit [15:0] op, w1, w2, w3;
      bit [14:0] a, b, c, v;
      bit        oka, okb, okc;
      bit [2:0]  fault;
      int        np;
      r = '0;
      if (!it.step) begin
         vm_mem[it.addr]     = it.data;
         vm_written[it.addr] = 1'b1;
         r.status = vm_stop;
         r.pc     = vm_pc;
         return;
      end
      if (vm_stop != ST_OK) begin
         r.status = vm_stop;
         r.pc     = vm_pc;
         return;
      end
      op  = mem_word(vm_pc);
      w1  = mem_word(vm_pc + 1);
      w2  = mem_word(vm_pc + 2);
      w3  = mem_word(vm_pc + 3);
      oka = operand(w1, a);
      okb = operand(w2, b);
      okc = operand(w3, c);
      np  = vm_pc;
      fault = ST_OK;
      if (op > 16'(OP_NOOP)) begin
         fault = ST_BAD_OP;
      end else begin
         case (opcode_type'(op[4:0]))
            OP_HALT: fault = ST_HALTED;
            OP_SET, OP_NOT, OP_RMEM: begin
               if (!is_reg(w1) || !okb) fault = ST_BAD_OPND;
               else begin
                  if (op == 16'(OP_SET))      v = b;
                  else if (op == 16'(OP_NOT)) v = ~b;
                  else                        v = 15'(mem_word(b));
                  vm_regs[w1[2:0]] = v;
                  np += 3;
               end
            end
            OP_PUSH: begin
               if (!oka) fault = ST_BAD_OPND;
               else if (vm_level >= STACK_WORDS) fault = ST_OVERFLOW;
               else begin
                  vm_stack[vm_level] = a;
                  vm_level++;
                  np += 2;
               end
            end
            OP_POP: begin
               if (!is_reg(w1)) fault = ST_BAD_OPND;
               else if (vm_level == 0) fault = ST_UNDERFLOW;
               else begin
                  vm_level--;
                  vm_regs[w1[2:0]] = vm_stack[vm_level];
                  np += 2;
               end
            end
            OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR: begin
               if (!is_reg(w1) || !okb || !okc) fault = ST_BAD_OPND;
               else if (op == 16'(OP_MOD) && c == 0) fault = ST_MOD_ZERO;
               else begin
                  case (opcode_type'(op[4:0]))
                     OP_EQ:   v = (b == c) ? 15'd1 : 15'd0;
                     OP_GT:   v = (b > c) ? 15'd1 : 15'd0;
                     OP_ADD:  v = b + c;
                     OP_MULT: v = 15'(30'(b) * 30'(c));
                     OP_MOD:  v = b % c;
                     OP_AND:  v = b & c;
                     default: v = b | c;
                  endcase
                  vm_regs[w1[2:0]] = v;
                  np += 4;
               end
            end
            OP_JMP: begin
               if (!oka) fault = ST_BAD_OPND;
               else np = a;
            end
            OP_JT, OP_JF: begin
               if (!oka || !okb) fault = ST_BAD_OPND;
               else if ((op == 16'(OP_JT)) == (a != 0)) np = b;
               else np += 3;
            end
            OP_WMEM: begin
               if (!oka || !okb) fault = ST_BAD_OPND;
               else begin
                  vm_mem[a]     = {1'b0, b};
                  vm_written[a] = 1'b1;
                  np += 3;
               end
            end
            OP_CALL: begin
               if (!oka) fault = ST_BAD_OPND;
               else if (vm_level >= STACK_WORDS) fault = ST_OVERFLOW;
               else begin
                  vm_stack[vm_level] = 15'(vm_pc + 2);
                  vm_level++;
                  np = a;
               end
            end
            OP_RET: begin
               if (vm_level == 0) fault = ST_HALTED;  // empty stack halts
               else begin
                  vm_level--;
                  np = vm_stack[vm_level];
               end
            end
            OP_OUT: begin
               if (!oka) fault = ST_BAD_OPND;
               else begin
                  r.oc     = a[7:0];
                  r.status = ST_CHAR;
                  np += 2;
               end
            end
            OP_IN: begin
               if (!is_reg(w1)) fault = ST_BAD_OPND;
               else begin
                  vm_regs[w1[2:0]] = {7'd0, it.ch};
                  r.used = 1'b1;
                  np += 2;
               end
            end
            default: np += 1;                       // NOOP
         endcase
      end
      if (fault != ST_OK) begin
         // a fault leaves everything but the stop code untouched
         vm_stop  = fault;
         r.status = fault;
         r.oc     = '0;
         r.used   = 1'b0;
      end else begin
         vm_pc = np[14:0];
      end
      r.pc = vm_pc;
   endtask

   // -------------------------------------------------------------------------
   // Request side: valid only drops when a gap is taken, never in the same
   // step that raises it again.
   // -------------------------------------------------------------------------
   task automatic send_item(input vm_req_type it, input bit typed,
                            input vm_rsp_type typed_rsp);
      vm_rsp_type predicted;
      vm_execute(it, predicted);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= it.step;
      req_ch.load_addr <= it.addr;
      req_ch.load_data <= it.data;
      req_ch.in_char   <= it.ch;
      do @(posedge clock); while (!req_ch.ready);
      sent_items++;
   endtask

   task automatic load_word(input int addr, input bit [15:0] data);
      vm_req_type it;
      it      = '0;
      it.addr = addr[14:0];
      it.data = data;
      it.ch   = 8'($urandom);
      send_item(it, 1'b0, '0);
   endtask

   task automatic step_once();
      vm_req_type it;
      it      = '0;
      it.step = 1'b1;
      it.addr = 15'($urandom);
      it.data = 16'($urandom_range(32775));
      it.ch   = 8'($urandom);
      send_item(it, 1'b0, '0);
   endtask

   // Literal or register source operand, extremes favored now and then.
   function automatic bit [15:0] src_word();
      case ($urandom_range(5))
         0, 1:    return REG_BASE + 16'($urandom_range(7));
         2:       return 16'h7FFF;
         3:       return 16'h0000;
         default: return 16'($urandom_range(16'h7FFF));
      endcase
   endfunction

   function automatic bit [15:0] dst_word();
      return REG_BASE + 16'($urandom_range(7));
   endfunction

   // Place one instruction at the program counter and step it.
   task automatic run_instruction(input bit [15:0] w0, input bit [15:0] w1,
                                  input bit [15:0] w2, input bit [15:0] w3);
      bit [14:0] base;
      base = vm_pc;
      load_word(base,     w0);
      load_word(base + 1, w1);
      load_word(base + 2, w2);
      load_word(base + 3, w3);
      step_once();
   endtask

   task automatic random_instruction();
      bit [15:0] op, w1, w2, w3;
      bit [14:0] v;
      bit        ok;
      bit [14:0] base;
      // scattered noise writes anywhere in memory
      if ($urandom_range(99) < 15)
         load_word($urandom_range(16'h7FFF), 16'($urandom_range(32775)));
      op = 16'($urandom_range(OP_SET, OP_NOOP));
      w1 = dst_word();
      w2 = src_word();
      w3 = src_word();
      case (opcode_type'(op[4:0]))
         OP_PUSH, OP_CALL, OP_OUT, OP_JMP, OP_JT, OP_JF, OP_WMEM: w1 = src_word();
         default: ;
      endcase
      if (op == 16'(OP_POP) && vm_level == 0) op = 16'(OP_PUSH);
      if (op == 16'(OP_RET) && vm_level == 0) op = 16'(OP_NOOP);
      if ((op == 16'(OP_PUSH) || op == 16'(OP_CALL)) && vm_level >= STACK_WORDS - 64)
         op = 16'(OP_POP);
      if (op == 16'(OP_PUSH)) w1 = src_word();
      if (op == 16'(OP_POP)) w1 = dst_word();
      if (op == 16'(OP_MOD)) begin
         ok = operand(w3, v);
         if (v == 0) w3 = 16'($urandom_range(1, 16'h7FFF));
      end
      base = vm_pc;
      load_word(base,     op);
      load_word(base + 1, w1);
      load_word(base + 2, w2);
      load_word(base + 3, w3);
      // RMEM must only read a word that has been written
      if (op == 16'(OP_RMEM)) begin
         ok = operand(w2, v);
         if (!vm_written[v]) load_word(v, 16'($urandom_range(32775)));
      end
      step_once();
   endtask

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      vm_rsp_type seen, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen = {rsp_ch.status, rsp_ch.out_char, rsp_ch.used_input, rsp_ch.pc_after};
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: status %0d char %h used %b pc %h",
                        seen.status, seen.oc, seen.used, seen.pc);
         end else begin
            want = pending_rsp.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st %0d ch %h in %b pc %h, got st %0d ch %h in %b pc %h",
                           want.status, want.oc, want.used, want.pc,
                           seen.status, seen.oc, seen.used, seen.pc);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic dir_row_type ld(input int addr, input bit [15:0] data, input int pc);
      dir_row_type row;
      row          = '0;
      row.req.addr = addr[14:0];
      row.req.data = data;
      row.rsp.pc   = pc[14:0];
      return row;
   endfunction

   function automatic dir_row_type st(input bit [7:0] ch, input status_type s,
                                      input bit [7:0] oc, input bit used, input int pc);
      dir_row_type row;
      row          = '0;
      row.req.step = 1'b1;
      row.req.ch   = ch;
      row.rsp      = {s, oc, used, pc[14:0]};
      return row;
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   dir_row_type directed [$];

   initial begin
      int kind;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = 1'b0;
      req_ch.load_addr = '0;
      req_ch.load_data = '0;
      req_ch.in_char   = '0;
      rsp_ch.ready     = 1'b0;
      send_idle  = 28;
      recv_idle  = 83;
      mismatches = 0;
      sent_items = 0;
      cycles     = 0;
      vm_level   = 0;
      vm_pc      = '0;
      vm_stop    = ST_OK;
      foreach (vm_regs[i]) vm_regs[i] = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // small program: SET r0 max, ADD wraps to zero, OUT of a wide value,
      // IN with all-ones char, NOOP; plus a load at the top address
      directed = '{
         ld(0, 16'(OP_SET), 0), ld(1, 16'h8000, 0), ld(2, 16'h7FFF, 0),
         ld(3, 16'(OP_ADD), 0), ld(4, 16'h8001, 0), ld(5, 16'h8000, 0),
         ld(6, 16'h0001, 0),    ld(7, 16'(OP_OUT), 0), ld(8, 16'h0141, 0),
         ld(9, 16'(OP_IN), 0),  ld(10, 16'h8007, 0), ld(11, 16'(OP_NOOP), 0),
         ld(12, 16'(OP_NOOP), 0), ld(13, 16'h0000, 0), ld(14, 16'h0000, 0),
         ld(15, 16'h0000, 0),   ld(16'h7FFF, 16'h8007, 0),
         st(8'h00, ST_OK, 8'h00, 1'b0, 3),
         st(8'h00, ST_OK, 8'h00, 1'b0, 7),
         st(8'h00, ST_CHAR, 8'h41, 1'b0, 9),
         st(8'hFF, ST_OK, 8'h00, 1'b1, 11),
         st(8'h00, ST_OK, 8'h00, 1'b0, 12)
      };
      foreach (directed[i])
         send_item(directed[i].req, 1'b1, directed[i].rsp);

      // three idle regimes
      while (sent_items < 170) random_instruction();
      send_idle = 83;
      recv_idle = 28;
      while (sent_items < 310) random_instruction();
      send_idle = 0;
      recv_idle = 0;
      while (sent_items < 440) random_instruction();

      // one fault to stop the machine, then items to a stopped core
      kind = $urandom_range(4);
      case (kind)
         0: run_instruction(16'(OP_HALT), src_word(), src_word(), src_word());
         1: run_instruction(16'(OP_SET), 16'($urandom_range(16'h7FFF)), src_word(),
                            src_word());
         2: run_instruction(16'($urandom_range(22, 32775)), src_word(), src_word(),
                            src_word());
         3: run_instruction(16'(OP_MOD), dst_word(), src_word(), 16'h0000);
         default: begin
            if (vm_level == 0)
               run_instruction($urandom_range(1) ? 16'(OP_POP) : 16'(OP_RET),
                               dst_word(), src_word(), src_word());
            else
               run_instruction(16'(OP_SET), 16'h0005, src_word(), src_word());
         end
      endcase
      step_once();
      load_word($urandom_range(16'h7FFF), 16'($urandom_range(32775)));
      step_once();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
